@@ hw/rtl/ckat_pkg.sv @@
// Shared types and constants for the char-keyed associative table.
`timescale 1ns / 1ps

package ckat_pkg;

   localparam int ENTRIES = 16;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // action codes
   localparam logic [2:0] ACT_INSERT     = 3'd0;
   localparam logic [2:0] ACT_FIND_KEY   = 3'd1;
   localparam logic [2:0] ACT_FIND_VALUE = 3'd2;
   localparam logic [2:0] ACT_READ       = 3'd3;
   localparam logic [2:0] ACT_MODIFY     = 3'd4;
   localparam logic [2:0] ACT_REMOVE     = 3'd5;

   // status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_BAD_INDEX = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  key;
      logic [15:0] value;
      logic [3:0]  index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  found_key;
      logic [15:0] found_value;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_FIND_KEY,
      CELL_FIND_VALUE,
      CELL_READ,
      CELL_INSERT,
      CELL_MODIFY,
      CELL_REMOVE
   } cell_op_type;

   // broadcast to every cell
   typedef struct packed {
      cell_op_type op;
      logic [7:0]  key;
      logic [15:0] value;
   } cell_ctl_type;

   // first-match chain running from cell 0 upward
   typedef struct packed {
      logic        hit;
      logic [7:0]  key;
      logic [15:0] value;
   } link_type;

endpackage

@@ hw/rtl/ckat_cell.sv @@
// One table slot: key/value storage, compare, and first-match link to its neighbor.
`timescale 1ns / 1ps

module ckat_cell (
   input  logic                  clock,
   input  ckat_pkg::cell_ctl_type ctl,
   input  logic                  commit,
   input  logic                  valid,
   input  logic                  at_index,
   input  logic                  at_tail,
   input  logic [7:0]            next_key,
   input  logic [15:0]           next_value,
   input  ckat_pkg::link_type    link_in,
   output ckat_pkg::link_type    link_out,
   output logic [7:0]            key_out,
   output logic [15:0]           value_out
);

   logic [7:0]  key_ff;
   logic [15:0] value_ff;
   logic        match;

   always_comb begin
      case (ctl.op)
         ckat_pkg::CELL_FIND_KEY,
         ckat_pkg::CELL_MODIFY,
         ckat_pkg::CELL_REMOVE:     match = valid && (key_ff == ctl.key);
         ckat_pkg::CELL_FIND_VALUE: match = valid && (value_ff == ctl.value);
         ckat_pkg::CELL_READ:       match = valid && at_index;
         default:                   match = 1'b0;
      endcase
   end

   always_comb begin
      link_out.hit = link_in.hit || match;
      if (link_in.hit) begin
         link_out.key   = link_in.key;
         link_out.value = link_in.value;
      end else if (match) begin
         link_out.key   = key_ff;
         link_out.value = value_ff;
      end else begin
         link_out.key   = '0;
         link_out.value = '0;
      end
   end

   // on remove, every slot at or after the first match pulls from its upper neighbor
   always_ff @(posedge clock) begin
      if (commit) begin
         case (ctl.op)
            ckat_pkg::CELL_INSERT: begin
               if (at_tail) begin
                  key_ff   <= ctl.key;
                  value_ff <= ctl.value;
               end
            end
            ckat_pkg::CELL_MODIFY: begin
               if (match) value_ff <= ctl.value;
            end
            ckat_pkg::CELL_REMOVE: begin
               if (link_in.hit || match) begin
                  key_ff   <= next_key;
                  value_ff <= next_value;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;

endmodule

@@ hw/rtl/char_keyed_associative_table_core.sv @@
// Top level: ordered byte-keyed table built as a chain of compare cells.
// Usage:
//   req_ channel carries one action (insert, find by key, find by value,
//   read at index, modify, remove). rsp_ channel returns exactly one result
//   per action: status, found key/value, and entry count afterwards.
//   A transaction moves at a clock edge with valid high and stall low.
// Execution:
//   A request is registered on acceptance and then executed, where all
//   cells compare at once and a first-match chain picks the answer.
//   A new request is stalled until the previous one has been executed.
//   Remove shifts the row down by one slot per matching entry, one entry
//   per shift of the cell row, until no match remains.
// Stalls:
//   The result sits in an output register; a new request is accepted while
//   it waits. Execution holds until that register frees; only the shifts
//   of a remove go ahead meanwhile.
// Reset:
//   Synchronous, active high. Entry count clears to zero; slot contents are
//   left as they are and are never read before being written.
`timescale 1ns / 1ps

module char_keyed_associative_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ckat_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ckat_pkg::rsp_type rsp_payload
);

   localparam int N = ckat_pkg::ENTRIES;
   localparam int CW = ckat_pkg::CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REMOVE
   } state_type;

   state_type             state_ff, state_in;
   ckat_pkg::req_type     cmd_ff, cmd_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ckat_pkg::rsp_type     rsp_ff, rsp_in;
   logic                  rm_hit_ff, rm_hit_in;
   logic [7:0]            rm_key_ff, rm_key_in;
   logic [15:0]           rm_value_ff, rm_value_in;

   ckat_pkg::cell_ctl_type ctl;
   logic                   commit;
   ckat_pkg::link_type     link [N+1];
   logic [7:0]             cell_key [N+1];
   logic [15:0]            cell_value [N+1];
   logic                   out_free;
   logic                   accept;
   logic                   full;
   logic                   bad_index;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == CW'(N));
   assign bad_index = (CW'(cmd_ff.index) >= count_ff);

   assign link[0]       = '0;
   assign cell_key[N]   = '0;
   assign cell_value[N] = '0;

   for (genvar i = 0; i < N; i++) begin : g_cell
      ckat_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .commit     (commit),
         .valid      (count_ff > CW'(i)),
         .at_index   (CW'(cmd_ff.index) == CW'(i)),
         .at_tail    (count_ff == CW'(i)),
         .next_key   (cell_key[i+1]),
         .next_value (cell_value[i+1]),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .key_out    (cell_key[i]),
         .value_out  (cell_value[i])
      );
   end

   // broadcast to the row depends on the held command only
   always_comb begin
      ctl.key   = cmd_ff.key;
      ctl.value = cmd_ff.value;
      case (cmd_ff.action)
         ckat_pkg::ACT_INSERT:     ctl.op = ckat_pkg::CELL_INSERT;
         ckat_pkg::ACT_FIND_KEY:   ctl.op = ckat_pkg::CELL_FIND_KEY;
         ckat_pkg::ACT_FIND_VALUE: ctl.op = ckat_pkg::CELL_FIND_VALUE;
         ckat_pkg::ACT_READ:       ctl.op = ckat_pkg::CELL_READ;
         ckat_pkg::ACT_MODIFY:     ctl.op = ckat_pkg::CELL_MODIFY;
         ckat_pkg::ACT_REMOVE:     ctl.op = ckat_pkg::CELL_REMOVE;
         default:                  ctl.op = ckat_pkg::CELL_IDLE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rm_hit_in    = rm_hit_ff;
      rm_key_in    = rm_key_ff;
      rm_value_in  = rm_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      commit       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = req_payload;
               rm_hit_in = 1'b0;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC, ST_REMOVE: begin
            if (cmd_ff.action == ckat_pkg::ACT_REMOVE && link[N].hit) begin
               // drop the first remaining match; record it if it is the first
               commit   = 1'b1;
               count_in = count_ff - CW'(1);
               state_in = ST_REMOVE;
               if (!rm_hit_ff) begin
                  rm_hit_in   = 1'b1;
                  rm_key_in   = link[N].key;
                  rm_value_in = link[N].value;
               end
            end else if (out_free) begin
               commit       = !(cmd_ff.action == ckat_pkg::ACT_INSERT && full);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               rsp_in.found_key   = '0;
               rsp_in.found_value = '0;
               rsp_in.status      = ckat_pkg::STS_OK;
               rsp_in.entry_count = 5'(count_ff);
               case (cmd_ff.action)
                  ckat_pkg::ACT_INSERT: begin
                     if (full) begin
                        rsp_in.status = ckat_pkg::STS_FULL;
                     end else begin
                        count_in           = count_ff + CW'(1);
                        rsp_in.entry_count = 5'(count_ff + CW'(1));
                     end
                  end
                  ckat_pkg::ACT_FIND_KEY,
                  ckat_pkg::ACT_FIND_VALUE: begin
                     if (link[N].hit) begin
                        rsp_in.found_key   = link[N].key;
                        rsp_in.found_value = link[N].value;
                     end else begin
                        rsp_in.status = ckat_pkg::STS_NOT_FOUND;
                     end
                  end
                  ckat_pkg::ACT_READ: begin
                     if (bad_index) begin
                        rsp_in.status = ckat_pkg::STS_BAD_INDEX;
                     end else begin
                        rsp_in.found_key   = link[N].key;
                        rsp_in.found_value = link[N].value;
                     end
                  end
                  ckat_pkg::ACT_MODIFY: begin
                     if (link[N].hit) begin
                        rsp_in.found_key   = cmd_ff.key;
                        rsp_in.found_value = cmd_ff.value;
                     end else begin
                        rsp_in.status = ckat_pkg::STS_NOT_FOUND;
                     end
                  end
                  ckat_pkg::ACT_REMOVE: begin
                     if (rm_hit_ff) begin
                        rsp_in.found_key   = rm_key_ff;
                        rsp_in.found_value = rm_value_ff;
                     end else begin
                        rsp_in.status = ckat_pkg::STS_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rm_hit_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rm_hit_ff    <= rm_hit_in;
      end
      cmd_ff      <= cmd_in;
      rsp_ff      <= rsp_in;
      rm_key_ff   <= rm_key_in;
      rm_value_ff <= rm_value_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N))
      else $error("entry count beyond table size");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction did not start execution");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && cmd_ff.action == ckat_pkg::ACT_REMOVE && link[N].hit)
      |=> count_ff == $past(count_ff) - CW'(1))
      else $error("remove shift did not reduce entry count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ckat_pkg::STS_FULL) |-> rsp_ff.entry_count == 5'(N))
      else $error("table full reported below capacity");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ckat_pkg::STS_OK)
      |-> (rsp_ff.found_key == '0 && rsp_ff.found_value == '0))
      else $error("failed transaction carries nonzero data");

endmodule
